// ----- hw/rtl/piecewise_linear_color_map_defines.svh -----
// ----------------------------------------------------------------------------
// piecewise_linear_color_map_defines.svh
// Assertion macros shared by the color map RTL.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_COLOR_MAP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLOR_MAP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PLCM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("color map assertion failed");

// Next-cycle implication.
`define PLCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("color map assertion failed");

// Implication after a fixed number of cycles.
`define PLCM_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("color map assertion failed");

`else

`define PLCM_ASSERT_IMP(label, clk, rst, ante, cons)
`define PLCM_ASSERT_NEXT(label, clk, rst, ante, cons)
`define PLCM_ASSERT_DELAY(label, clk, rst, ante, n, cons)

`endif

`endif

// ----- hw/rtl/plcm_pkg.sv -----
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared constants and types for the piecewise linear color map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plcm_pkg;

  localparam int DEF_LEVEL_BITS   = 16;
  localparam int DEF_CHANNEL_BITS = 8;

  // Blend factor is Q1.16, saturated to 1.0.
  localparam int FRAC_BITS  = 16;
  localparam int NUM_STOPS  = 5;
  // Segment reciprocals stay below 2^20 for any level width.
  localparam int RECIP_BITS = 20;

  // Stop boundaries in percent of full scale.
  localparam logic [63:0] BOUND_PCT_0 = 64'd10;
  localparam logic [63:0] BOUND_PCT_1 = 64'd38;
  localparam logic [63:0] BOUND_PCT_2 = 64'd50;
  localparam logic [63:0] BOUND_PCT_3 = 64'd62;
  localparam logic [63:0] BOUND_PCT_4 = 64'd90;

  // Reset colors, packed red/green/blue at 8 bits a channel.
  localparam logic [63:0] STOP_RESET_0 = 64'h0000FF;
  localparam logic [63:0] STOP_RESET_1 = 64'h00AAFF;
  localparam logic [63:0] STOP_RESET_2 = 64'hFF0000;
  localparam logic [63:0] STOP_RESET_3 = 64'hFFAA00;
  localparam logic [63:0] STOP_RESET_4 = 64'hFFFF00;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_STOP_COLOR_0 = 3'd0;
  localparam cfg_index_t REG_STOP_COLOR_1 = 3'd1;
  localparam cfg_index_t REG_STOP_COLOR_2 = 3'd2;
  localparam cfg_index_t REG_STOP_COLOR_3 = 3'd3;
  localparam cfg_index_t REG_STOP_COLOR_4 = 3'd4;

  // Segment codes: below the first stop, the four blend segments, above the last.
  typedef logic [2:0] seg_t;
  localparam seg_t SEG_LOW  = 3'd0;
  localparam seg_t SEG_1    = 3'd1;
  localparam seg_t SEG_2    = 3'd2;
  localparam seg_t SEG_3    = 3'd3;
  localparam seg_t SEG_4    = 3'd4;
  localparam seg_t SEG_HIGH = 3'd5;

endpackage

`default_nettype wire

// ----- hw/rtl/piecewise_linear_color_map.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_color_map
// Result: the done strobe comes with the color of each accepted start.
// Throughput: one level per cycle; busy stays low, so start may come every cycle.
// Depth: five stages (segment compare, reciprocal multiply, factor clamp and
// color select, blend multiply, round); the receiver cannot stall.
// Reset: rst (synchronous) clears the valids and loads the default stop colors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "piecewise_linear_color_map_defines.svh"

module piecewise_linear_color_map #(
  parameter int LEVEL_BITS   = plcm_pkg::DEF_LEVEL_BITS,
  parameter int CHANNEL_BITS = plcm_pkg::DEF_CHANNEL_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // level command
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [LEVEL_BITS-1:0]             level,
  // color result strobe
  output logic                                   done,
  output logic [CHANNEL_BITS-1:0]                red,
  output logic [CHANNEL_BITS-1:0]                green,
  output logic [CHANNEL_BITS-1:0]                blue,
  // configuration write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [plcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [3*CHANNEL_BITS-1:0]         cfg_data
);

  localparam int FB         = plcm_pkg::FRAC_BITS;
  localparam int RB         = plcm_pkg::RECIP_BITS;
  localparam int COLOR_BITS = 3 * CHANNEL_BITS;
  localparam int PROD_BITS  = LEVEL_BITS + RB;

  typedef logic [LEVEL_BITS-1:0]   level_t;
  typedef logic [RB-1:0]           recip_t;
  typedef logic [PROD_BITS-1:0]    prod_t;
  typedef logic [FB:0]             frac_t;
  typedef logic [COLOR_BITS-1:0]   color_t;
  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic signed [CHANNEL_BITS:0] delta_t;

  // Stop boundaries, rounded to the level grid.
  localparam logic [63:0] BOUND_0 = ((plcm_pkg::BOUND_PCT_0 << LEVEL_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] BOUND_1 = ((plcm_pkg::BOUND_PCT_1 << LEVEL_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] BOUND_2 = ((plcm_pkg::BOUND_PCT_2 << LEVEL_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] BOUND_3 = ((plcm_pkg::BOUND_PCT_3 << LEVEL_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] BOUND_4 = ((plcm_pkg::BOUND_PCT_4 << LEVEL_BITS) + 64'd50) / 64'd100;

  localparam logic [63:0] WIDTH_0 = BOUND_1 - BOUND_0;
  localparam logic [63:0] WIDTH_1 = BOUND_2 - BOUND_1;
  localparam logic [63:0] WIDTH_2 = BOUND_3 - BOUND_2;
  localparam logic [63:0] WIDTH_3 = BOUND_4 - BOUND_3;

  // Rounded reciprocals of the segment widths, scaled so that
  // (level - lo) * recip >> LEVEL_BITS is a Q1.16 factor.
  localparam logic [63:0] ONE_SCALED = 64'd1 << (FB + LEVEL_BITS);
  localparam logic [63:0] RECIP_0 = (ONE_SCALED + WIDTH_0 / 64'd2) / WIDTH_0;
  localparam logic [63:0] RECIP_1 = (ONE_SCALED + WIDTH_1 / 64'd2) / WIDTH_1;
  localparam logic [63:0] RECIP_2 = (ONE_SCALED + WIDTH_2 / 64'd2) / WIDTH_2;
  localparam logic [63:0] RECIP_3 = (ONE_SCALED + WIDTH_3 / 64'd2) / WIDTH_3;

  localparam frac_t FRAC_ONE = frac_t'(1) << FB;

  // --------------------------------------------------------------------------
  // Configuration: stop color registers. A write needs no wait state, so the
  // port is always ready. Indexes past the last stop are dropped.
  // --------------------------------------------------------------------------
  color_t stop_color [plcm_pkg::NUM_STOPS];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_color[0] <= color_t'(plcm_pkg::STOP_RESET_0);
      stop_color[1] <= color_t'(plcm_pkg::STOP_RESET_1);
      stop_color[2] <= color_t'(plcm_pkg::STOP_RESET_2);
      stop_color[3] <= color_t'(plcm_pkg::STOP_RESET_3);
      stop_color[4] <= color_t'(plcm_pkg::STOP_RESET_4);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        plcm_pkg::REG_STOP_COLOR_0: stop_color[0] <= cfg_data;
        plcm_pkg::REG_STOP_COLOR_1: stop_color[1] <= cfg_data;
        plcm_pkg::REG_STOP_COLOR_2: stop_color[2] <= cfg_data;
        plcm_pkg::REG_STOP_COLOR_3: stop_color[3] <= cfg_data;
        plcm_pkg::REG_STOP_COLOR_4: stop_color[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid pipeline. One bit per stage travels beside the data; nothing
  // downstream can stall, so every stage advances every cycle.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: find the segment. A level exactly on a boundary belongs to the
  // segment below it. Offset from the segment's low boundary.
  // --------------------------------------------------------------------------
  plcm_pkg::seg_t seg_next, seg1;
  level_t         diff_next, diff1;

  always_comb begin
    seg_next  = plcm_pkg::SEG_HIGH;
    diff_next = '0;
    if (level <= level_t'(BOUND_0)) begin
      seg_next = plcm_pkg::SEG_LOW;
    end else if (level <= level_t'(BOUND_1)) begin
      seg_next  = plcm_pkg::SEG_1;
      diff_next = level - level_t'(BOUND_0);
    end else if (level <= level_t'(BOUND_2)) begin
      seg_next  = plcm_pkg::SEG_2;
      diff_next = level - level_t'(BOUND_1);
    end else if (level <= level_t'(BOUND_3)) begin
      seg_next  = plcm_pkg::SEG_3;
      diff_next = level - level_t'(BOUND_2);
    end else if (level <= level_t'(BOUND_4)) begin
      seg_next  = plcm_pkg::SEG_4;
      diff_next = level - level_t'(BOUND_3);
    end
  end

  always_ff @(posedge clk) begin
    seg1  <= seg_next;
    diff1 <= diff_next;
  end

  // --------------------------------------------------------------------------
  // Stage 2: offset times the segment reciprocal.
  // --------------------------------------------------------------------------
  recip_t         recip;
  plcm_pkg::seg_t seg2;
  prod_t          prod2;

  always_comb begin
    case (seg1)
      plcm_pkg::SEG_1: recip = recip_t'(RECIP_0);
      plcm_pkg::SEG_2: recip = recip_t'(RECIP_1);
      plcm_pkg::SEG_3: recip = recip_t'(RECIP_2);
      plcm_pkg::SEG_4: recip = recip_t'(RECIP_3);
      default:         recip = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    seg2  <= seg1;
    prod2 <= prod_t'(diff1) * prod_t'(recip);
  end

  // --------------------------------------------------------------------------
  // Stage 3: truncate to Q1.16 and clamp at 1.0 (reciprocal rounding can
  // overshoot at a segment's top). Pick the two stops of the segment and
  // form the per-channel difference. Outside the stops, blend from the end
  // stop with a zero factor.
  // --------------------------------------------------------------------------
  recip_t         frac_raw;
  frac_t          frac_next, f3;
  color_t         col_lo, col_hi;
  plcm_pkg::seg_t seg3;
  chan_t          clo3 [3];
  delta_t         delta3 [3];

  assign frac_raw = prod2[LEVEL_BITS +: RB];

  always_comb begin
    frac_next = (frac_raw > recip_t'(FRAC_ONE)) ? FRAC_ONE : frac_raw[FB:0];
    col_lo    = stop_color[0];
    col_hi    = stop_color[0];
    case (seg2)
      plcm_pkg::SEG_LOW: begin
        frac_next = '0;
      end
      plcm_pkg::SEG_1: begin
        col_lo = stop_color[0];
        col_hi = stop_color[1];
      end
      plcm_pkg::SEG_2: begin
        col_lo = stop_color[1];
        col_hi = stop_color[2];
      end
      plcm_pkg::SEG_3: begin
        col_lo = stop_color[2];
        col_hi = stop_color[3];
      end
      plcm_pkg::SEG_4: begin
        col_lo = stop_color[3];
        col_hi = stop_color[4];
      end
      default: begin
        col_lo    = stop_color[4];
        col_hi    = stop_color[4];
        frac_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    seg3 <= seg2;
    f3   <= frac_next;
    for (int k = 0; k < 3; k++) begin
      // channel 0 red in the top bits, 2 blue in the low bits
      clo3[k]   <= col_lo[(2 - k) * CHANNEL_BITS +: CHANNEL_BITS];
      delta3[k] <= delta_t'(col_hi[(2 - k) * CHANNEL_BITS +: CHANNEL_BITS])
                 - delta_t'(col_lo[(2 - k) * CHANNEL_BITS +: CHANNEL_BITS]);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5: one blend lane per channel.
  // --------------------------------------------------------------------------
  chan_t chan_out [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    plcm_lane #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane (
      .clk   (clk),
      .c_lo  (clo3[k]),
      .delta (delta3[k]),
      .frac  (f3),
      .chan  (chan_out[k])
    );
  end

  assign red   = chan_out[0];
  assign green = chan_out[1];
  assign blue  = chan_out[2];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PLCM_ASSERT_DELAY(a_start_to_done, clk, rst, start && !busy, 5, done)
  `PLCM_ASSERT_IMP(a_done_has_start, clk, rst, done, $past(start && !busy, 5))
  `PLCM_ASSERT_IMP(a_frac_clamped, clk, rst, v3, f3 <= FRAC_ONE)
  `PLCM_ASSERT_IMP(a_ends_no_blend, clk, rst,
                   v3 && (seg3 == plcm_pkg::SEG_LOW || seg3 == plcm_pkg::SEG_HIGH),
                   f3 == '0)
  `PLCM_ASSERT_NEXT(a_cfg_lands, clk, rst,
                    cfg_valid && cfg_index == plcm_pkg::REG_STOP_COLOR_2,
                    stop_color[2] == $past(cfg_data))

endmodule

`default_nettype wire

// ----- hw/rtl/plcm_lane.sv -----
// ----------------------------------------------------------------------------
// plcm_lane
// One color channel blend: multiply the stop difference by the factor,
// then add the low stop and round to the channel width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plcm_lane #(
  parameter int CHANNEL_BITS = plcm_pkg::DEF_CHANNEL_BITS
) (
  input  wire logic                                  clk,
  input  wire logic [CHANNEL_BITS-1:0]               c_lo,
  input  wire logic signed [CHANNEL_BITS:0]          delta,
  input  wire logic [plcm_pkg::FRAC_BITS:0]          frac,
  output logic      [CHANNEL_BITS-1:0]               chan
);

  localparam int FB      = plcm_pkg::FRAC_BITS;
  localparam int MIX_W   = CHANNEL_BITS + FB + 3;

  typedef logic signed [MIX_W-1:0] mix_t;

  mix_t                     prod;
  logic [CHANNEL_BITS-1:0]  c_lo_d;
  mix_t                     mix;

  // Stage: signed product of stop difference and factor.
  always_ff @(posedge clk) begin
    prod   <= mix_t'(delta) * mix_t'(frac);
    c_lo_d <= c_lo;
  end

  // lo * 1.0 + (hi - lo) * f, rounded half up
  assign mix = (mix_t'(c_lo_d) <<< FB) + prod + (mix_t'(1) <<< (FB - 1));

  always_ff @(posedge clk) begin
    chan <= mix[FB +: CHANNEL_BITS];
  end

endmodule

`default_nettype wire
